FILE: hdl/mxbq_pkg.sv
package mxbq_pkg;

    localparam int BLOCK_VALUES = 32;
    localparam int HALF_VALUES  = BLOCK_VALUES / 2;
    localparam int PAIR_W       = $clog2(HALF_VALUES);
    localparam int STAGES       = $clog2(HALF_VALUES);

    localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
    localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;
    localparam logic [31:0] ROUND_ADD  = 32'h0020_0000;

    typedef logic [BLOCK_VALUES-1:0][15:0] block_t;

    typedef struct packed {
        logic [15:0] value_high;
        logic [15:0] value_low;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [7:0] shared_exponent;
        logic       last_of_block;
    } out_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_XFORM,
        B_QUARTER,
        B_SCAN,
        B_EXPO,
        B_EMIT
    } back_state_t;

    // fp32 add, round to nearest even
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [26:0] mx;
        logic [26:0] my;
        logic [7:0]  d;
        logic [5:0]  sh;
        logic [54:0] t;
        logic [27:0] sum;
        logic [8:0]  e;
        logic [4:0]  lz;
        logic        up;
        logic [30:0] pk;
        logic [31:0] r;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:0] == FP_INF_MAG);
        b_inf = (b[30:0] == FP_INF_MAG);
        r = FP_QNAN;
        if (a_nan || b_nan)
        begin
            r = FP_QNAN;
        end
        else if (a_inf && b_inf)
        begin
            r = (a[31] == b[31]) ? a : FP_QNAN;
        end
        else if (a_inf)
        begin
            r = a;
        end
        else if (b_inf)
        begin
            r = b;
        end
        else
        begin
            if (a[30:0] >= b[30:0])
            begin
                x = a;
                y = b;
            end
            else
            begin
                x = b;
                y = a;
            end
            ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
            ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
            mx = {x[30:23] != 8'd0, x[22:0], 3'b000};
            my = {y[30:23] != 8'd0, y[22:0], 3'b000};
            d  = ex - ey;
            sh = (d > 8'd27) ? 6'd28 : d[5:0];
            t  = {my, 28'd0} >> sh;
            my = t[54:28];
            my[0] = my[0] | (t[27:0] != 28'd0);
            e = {1'b0, ex};
            if (x[31] == y[31])
            begin
                sum = {1'b0, mx} + {1'b0, my};
                if (sum[27])
                begin
                    sum = {1'b0, sum[27:2], sum[1] | sum[0]};
                    e = e + 9'd1;
                end
            end
            else
            begin
                sum = {1'b0, mx} - {1'b0, my};
            end
            if (sum == 28'd0)
            begin
                r = (x[31] == y[31]) ? {x[31], 31'd0} : 32'd0;
            end
            else
            begin
                lz = 5'd0;
                for (int i = 0; i < 27; i++)
                begin
                    if (sum[i])
                        lz = 5'(26 - i);
                end
                if (e > {4'd0, lz})
                begin
                    sum = sum << lz;
                    e = e - {4'd0, lz};
                end
                else
                begin
                    sum = sum << (e - 9'd1);
                    e = 9'd0;
                end
                if (e >= 9'd255)
                begin
                    r = {x[31], FP_INF_MAG};
                end
                else
                begin
                    up = sum[2] & (sum[1] | sum[0] | sum[3]);
                    pk = {e[7:0], sum[25:3]} + {30'd0, up};
                    r = {x[31], pk};
                end
            end
        end
        return r;
    endfunction

    // x * 0.25, round to nearest even
    function automatic logic [31:0] fp_quarter(input logic [31:0] x);
        logic [7:0]  ex;
        logic [23:0] m;
        logic [1:0]  sh;
        logic [25:0] t;
        logic        up;
        logic [23:0] res;
        logic [31:0] r;
        ex = x[30:23];
        if (ex == 8'hFF)
        begin
            r = x;
        end
        else if (ex >= 8'd3)
        begin
            r = {x[31], ex - 8'd2, x[22:0]};
        end
        else
        begin
            m   = {ex != 8'd0, x[22:0]};
            sh  = (ex == 8'd0) ? 2'd2 : 2'(8'd3 - ex);
            t   = {m, 2'b00} >> sh;
            up  = t[1] & (t[0] | t[2]);
            res = t[25:2] + {23'd0, up};
            r   = {x[31], 7'd0, res};
        end
        return r;
    endfunction

    // E2M1 code of x * 2^k
    function automatic logic [3:0] e2m1_code(input logic [31:0] x, input logic signed [8:0] k);
        logic [7:0]         ex;
        logic [22:0]        f;
        logic [4:0]         p;
        logic [23:0]        tmp;
        logic [22:0]        fr;
        logic signed [10:0] ek;
        logic [2:0]         mag;
        logic [3:0]         r;
        ex = x[30:23];
        f  = x[22:0];
        p  = 5'd0;
        mag = 3'd0;
        if (ex == 8'hFF)
        begin
            r = (f != 23'd0) ? 4'd0 : {x[31], 3'd7};
        end
        else if (x[30:0] == 31'd0)
        begin
            r = {x[31], 3'd0};
        end
        else
        begin
            if (ex == 8'd0)
            begin
                for (int i = 0; i < 23; i++)
                begin
                    if (f[i])
                        p = 5'(i);
                end
                tmp = {1'b0, f} << (5'd23 - p);
                fr  = tmp[22:0];
                ek  = 11'(signed'({6'd0, p})) - 11'sd149 + 11'(k);
            end
            else
            begin
                fr = f;
                ek = 11'(signed'({3'd0, ex})) - 11'sd127 + 11'(k);
            end
            if (ek < -11'sd2)
                mag = 3'd0;
            else if (ek == -11'sd2)
                mag = 3'd1;
            else if (ek == -11'sd1)
                mag = fr[22] ? 3'd2 : 3'd1;
            else if (ek == 11'sd0)
                mag = (fr[22] & fr[21]) ? 3'd4 : ((fr[22] | fr[21]) ? 3'd3 : 3'd2);
            else if (ek == 11'sd1)
                mag = (fr[22] & fr[21]) ? 3'd6 : ((fr[22] | fr[21]) ? 3'd5 : 3'd4);
            else if (ek == 11'sd2)
                mag = (fr[22] | fr[21]) ? 3'd7 : 3'd6;
            else
                mag = 3'd7;
            r = {x[31], mag};
        end
        return r;
    endfunction

endpackage

FILE: hdl/mxbq_front.sv
module mxbq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mxbq_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              push,
    output mxbq_pkg::block_t  push_data
);
    import mxbq_pkg::*;

    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W-1:0] pair_next;
    logic [15:0]       hold_reg [BLOCK_VALUES];
    logic              accept;
    logic              last_pair;

    assign last_pair = (pair_reg == PAIR_W'(HALF_VALUES - 1));
    assign in_stall  = last_pair & q_full;
    assign accept    = in_valid & ~in_stall;
    assign push      = accept & last_pair;
    assign pair_next = accept ? pair_reg + PAIR_W'(1) : pair_reg;

    always_comb
    begin
        for (int i = 0; i < BLOCK_VALUES - 2; i++)
            push_data[i] = hold_reg[i];
        push_data[BLOCK_VALUES-2] = in_data.value_low;
        push_data[BLOCK_VALUES-1] = in_data.value_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_reg <= '0;
        else
            pair_reg <= pair_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg[{pair_reg, 1'b0}] <= in_data.value_low;
            hold_reg[{pair_reg, 1'b1}] <= in_data.value_high;
        end
    end

endmodule

FILE: hdl/mxbq_queue.sv
module mxbq_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mxbq_pkg::block_t push_data,
    output logic             full,
    output logic             valid,
    output mxbq_pkg::block_t data,
    input  logic             pop
);
    import mxbq_pkg::*;

    block_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/mxbq_back.sv
module mxbq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hadamard_enable,
    input  logic               q_valid,
    input  mxbq_pkg::block_t   q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output mxbq_pkg::out_item_t out_data
);
    import mxbq_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [PAIR_W-1:0]  cnt_reg;
    logic [PAIR_W-1:0]  cnt_next;
    logic [31:0]        v_reg [BLOCK_VALUES];
    logic [31:0]        v_next [BLOCK_VALUES];
    logic [30:0]        amax_reg;
    logic [30:0]        amax_next;
    logic [7:0]         e8_reg;
    logic [7:0]         e8_next;
    logic signed [8:0]  k_reg;
    logic signed [8:0]  k_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;
    logic [4:0]         span;
    logic [31:0]        rounded;
    logic [7:0]         expo;
    logic [30:0]        m0;
    logic [30:0]        m1;
    logic [30:0]        amax_tmp;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        amax_next      = amax_reg;
        e8_next        = e8_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & out_stall;
        q_pop          = 1'b0;
        span           = 5'd1 << cnt_reg[1:0];
        rounded        = {1'b0, amax_reg} + ROUND_ADD;
        expo           = rounded[30:23];
        m0             = v_reg[0][30:0];
        m1             = v_reg[1][30:0];
        amax_tmp       = amax_reg;
        for (int i = 0; i < BLOCK_VALUES; i++)
            v_next[i] = v_reg[i];

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    for (int i = 0; i < BLOCK_VALUES; i++)
                        v_next[i] = {q_data[i], 16'd0};
                    cnt_next   = '0;
                    amax_next  = '0;
                    state_next = hadamard_enable ? B_XFORM : B_SCAN;
                end
            end
            B_XFORM:
            begin
                for (int i = 0; i < BLOCK_VALUES; i++)
                begin
                    if ((5'(i) & span) == 5'd0)
                        v_next[i] = fp_add(v_reg[i], v_reg[5'(i) | span]);
                    else
                        v_next[i] = fp_add(v_reg[5'(i) ^ span],
                                           {~v_reg[i][31], v_reg[i][30:0]});
                end
                cnt_next = cnt_reg + PAIR_W'(1);
                if (cnt_reg == PAIR_W'(STAGES - 1))
                begin
                    cnt_next   = '0;
                    state_next = B_QUARTER;
                end
            end
            B_QUARTER:
            begin
                for (int i = 0; i < BLOCK_VALUES; i++)
                    v_next[i] = fp_quarter(v_reg[i]);
                state_next = B_SCAN;
            end
            B_SCAN:
            begin
                if (m0 <= FP_INF_MAG && m0 > amax_tmp)
                    amax_tmp = m0;
                if (m1 <= FP_INF_MAG && m1 > amax_tmp)
                    amax_tmp = m1;
                amax_next = amax_tmp;
                for (int i = 0; i < BLOCK_VALUES; i++)
                    v_next[i] = v_reg[(i + 2) % BLOCK_VALUES];
                cnt_next = cnt_reg + PAIR_W'(1);
                if (cnt_reg == PAIR_W'(HALF_VALUES - 1))
                    state_next = B_EXPO;
            end
            B_EXPO:
            begin
                if (amax_reg == 31'd0)
                    e8_next = 8'd127;
                else if (expo == 8'd255)
                    e8_next = 8'd254;
                else if (expo <= 8'd2)
                    e8_next = 8'd0;
                else
                    e8_next = expo - 8'd2;
                k_next     = 9'sd127 - signed'({1'b0, e8_next});
                cnt_next   = '0;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.packed_byte     = {e2m1_code(v_reg[1], k_reg),
                                                     e2m1_code(v_reg[0], k_reg)};
                    out_data_next.shared_exponent = e8_reg;
                    out_data_next.last_of_block   = (cnt_reg == PAIR_W'(HALF_VALUES - 1));
                    for (int i = 0; i < BLOCK_VALUES; i++)
                        v_next[i] = v_reg[(i + 2) % BLOCK_VALUES];
                    cnt_next = cnt_reg + PAIR_W'(1);
                    if (cnt_reg == PAIR_W'(HALF_VALUES - 1))
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK_VALUES; i++)
            v_reg[i] <= v_next[i];
        amax_reg     <= amax_next;
        e8_reg       <= e8_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: hdl/mxfp4_block_quantizer_unit.sv
// Channel   Direction  Payload       Transfer
// config    in         1 bit         cfg_write_enable
// in        in         in_item_t     in_valid && !in_stall
// out       out        out_item_t    out_valid && !out_stall
//
// Input takes one pair a cycle while in_stall is low; a block of 16 pairs goes to a two-block queue.
// The back end works on one block at a time: load, 4 butterfly passes and a quarter scale
// (transform only), max scan over the pairs, exponent, then 16 output bytes.
// Sustained rate is set by that back end.
// Reset clears control state and the register; no clearing pass.
// in_stall rises only on the last pair of a block while the queue is full.
module mxfp4_block_quantizer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_enable,
    input  logic                cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mxbq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mxbq_pkg::out_item_t out_data
);
    import mxbq_pkg::*;

    logic   hen_reg;
    logic   hen_next;
    logic   push;
    block_t push_data;
    logic   q_full;
    logic   q_valid;
    block_t q_data;
    logic   q_pop;

    assign hen_next = cfg_write_enable ? cfg_write_data : hen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hen_reg <= 1'b0;
        else
            hen_reg <= hen_next;
    end

    mxbq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    mxbq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .valid     (q_valid),
        .data      (q_data),
        .pop       (q_pop)
    );

    mxbq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .hadamard_enable (hen_reg),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data)
    );

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled with room in queue");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.shared_exponent != 8'd255)
        else $error("shared exponent out of range");

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mxbq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 300;

    localparam logic [30:0] QUANT_STEP [7] = '{31'h3E80_0000, 31'h3F40_0000, 31'h3FA0_0000,
        31'h3FE0_0000, 31'h4020_0000, 31'h4060_0000, 31'h40A0_0000};

    typedef struct {
        in_item_t pair;
        int       typed_expo;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write_enable = 1'b0;
    logic      cfg_write_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    out_item_t   pending_bytes[$];
    logic [15:0] held_values[BLOCK_VALUES];
    int          pairs_held = 0;
    logic        xform_on = 1'b0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;
    int          quiet_cycles = 0;

    mxfp4_block_quantizer_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

    always #5 clk = ~clk;

    // value = mag * 2^scale_exp, rounded to fp32 nearest even
    function automatic logic [31:0] fp32_round(input logic sgn, input logic [319:0] mag,
                                              input int scale_exp);
        int           msb;
        int           sh;
        int           eu;
        int           biased;
        logic [319:0] m;
        logic [319:0] rem;
        logic [319:0] half;
        if (mag == '0)
            return {sgn, 31'd0};
        msb = 0;
        for (int i = 0; i < 320; i++)
        begin
            if (mag[i])
                msb = i;
        end
        sh = msb - 23;
        if (-149 - scale_exp > sh)
            sh = -149 - scale_exp;
        if (sh > 0)
        begin
            m = mag >> sh;
            rem = mag - (m << sh);
            half = 320'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0]))
                m = m + 1;
        end
        else
        begin
            m = mag << (-sh);
        end
        eu = scale_exp + sh;
        if (m[24])
        begin
            m = m >> 1;
            eu = eu + 1;
        end
        if (m < 320'h80_0000)
            return {sgn, 8'd0, m[22:0]};
        biased = eu + 150;
        if (biased >= 255)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(biased), m[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
        int           ea;
        int           eb;
        int           emin;
        logic [319:0] ma;
        logic [319:0] mb;
        if (is_nan(a) || is_nan(b))
            return 32'h7FC0_0000;
        if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000)
            return (a[31] == b[31]) ? a : 32'h7FC0_0000;
        if (a[30:0] == 31'h7F80_0000)
            return a;
        if (b[30:0] == 31'h7F80_0000)
            return b;
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        emin = (ea < eb) ? ea : eb;
        ma = 320'({a[30:23] != 0, a[22:0]}) << (ea - emin);
        mb = 320'({b[30:23] != 0, b[22:0]}) << (eb - emin);
        if (a[31] == b[31])
            return fp32_round(a[31], ma + mb, emin - 150);
        if (ma == mb)
            return 32'd0;
        if (ma > mb)
            return fp32_round(a[31], ma - mb, emin - 150);
        return fp32_round(b[31], mb - ma, emin - 150);
    endfunction

    function automatic logic [31:0] fp32_pow2_mul(input logic [31:0] x, input int k);
        int e;
        if (x[30:23] == 8'hFF || x[30:0] == 0)
            return x;
        e = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        return fp32_round(x[31], 320'({x[30:23] != 0, x[22:0]}), e - 150 + k);
    endfunction

    function automatic logic [3:0] e2m1_of(input logic [31:0] x);
        logic [2:0] level;
        if (is_nan(x))
            return 4'd0;
        level = 3'd0;
        foreach (QUANT_STEP[i])
        begin
            if (x[30:0] >= QUANT_STEP[i])
                level = level + 3'd1;
        end
        return {x[31], level};
    endfunction

    task automatic quantize_block();
        logic [31:0] v[BLOCK_VALUES];
        logic [31:0] p;
        logic [31:0] q;
        logic [30:0] amax;
        logic [31:0] rounded;
        logic [7:0]  expo;
        logic [7:0]  e8;
        out_item_t   o;
        amax = '0;
        foreach (v[i])
            v[i] = {held_values[i], 16'd0};
        if (xform_on)
        begin
            for (int h = 0; h < BLOCK_VALUES; h += HALF_VALUES)
            begin
                for (int span = 1; span < HALF_VALUES; span <<= 1)
                begin
                    for (int st = 0; st < HALF_VALUES; st += 2 * span)
                    begin
                        for (int i = 0; i < span; i++)
                        begin
                            p = v[h + st + i];
                            q = v[h + st + span + i];
                            v[h + st + i] = fp32_sum(p, q);
                            v[h + st + span + i] = fp32_sum(p, {~q[31], q[30:0]});
                        end
                    end
                end
                for (int i = 0; i < HALF_VALUES; i++)
                    v[h + i] = fp32_pow2_mul(v[h + i], -2);
            end
        end
        foreach (v[i])
        begin
            if (!is_nan(v[i]) && v[i][30:0] > amax)
                amax = v[i][30:0];
        end
        rounded = ({1'b0, amax} + 32'h0020_0000) & 32'hFF80_0000;
        expo = rounded[30:23];
        if (amax == 0)
            e8 = 8'd127;
        else if (expo == 0)
            e8 = 8'd0;
        else if (expo == 8'hFF)
            e8 = 8'd254;
        else if (expo < 8'd2)
            e8 = 8'd0;
        else
            e8 = expo - 8'd2;
        for (int i = 0; i < HALF_VALUES; i++)
        begin
            o.packed_byte = {e2m1_of(fp32_pow2_mul(v[2*i+1], 127 - int'(e8))),
                             e2m1_of(fp32_pow2_mul(v[2*i], 127 - int'(e8)))};
            o.shared_exponent = e8;
            o.last_of_block = (i == HALF_VALUES - 1);
            pending_bytes.push_back(o);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            held_values[2*pairs_held] = in_data.value_low;
            held_values[2*pairs_held+1] = in_data.value_high;
            if (pairs_held == HALF_VALUES - 1)
            begin
                pairs_held = 0;
                quantize_block();
            end
            else
            begin
                pairs_held = pairs_held + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %h", out_data);
            end
            else
            begin
                if (out_data !== pending_bytes[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: byte %h/%h expo %h/%h last %b/%b (exp/act)",
                                 pending_bytes[0].packed_byte, out_data.packed_byte,
                                 pending_bytes[0].shared_exponent, out_data.shared_exponent,
                                 pending_bytes[0].last_of_block, out_data.last_of_block);
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_stall <= 1'b1;
            recv_hold <= recv_hold - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_pair(input in_item_t pair);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= pair;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_write(input logic enable);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= enable;
        xform_on = enable;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    function automatic logic [15:0] random_value(input int base);
        logic s;
        s = $urandom_range(1);
        case ($urandom_range(19))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return {s, 8'd0, 7'($urandom_range(1, 127))};
            3: return {s, 15'h7F80};
            4: return {s, 8'hFF, 7'($urandom_range(1, 127))};
            5: return 16'($urandom);
            6: return {s, 15'h7F7F};
            default: return {s, 8'(base + $urandom_range(8)), 7'($urandom)};
        endcase
    endfunction

    task automatic random_blocks(input int count);
        int       base;
        logic     zero_block;
        in_item_t pair;
        for (int b = 0; b < count; b++)
        begin
            base = $urandom_range(1, 246);
            zero_block = ($urandom_range(14) == 0);
            for (int i = 0; i < HALF_VALUES; i++)
            begin
                pair.value_low = zero_block ? 16'h0 : random_value(base);
                pair.value_high = zero_block ? 16'h0 : random_value(base);
                send_pair(pair);
            end
        end
    endtask

    stim_row_t directed[$];

    initial
    begin
        for (int i = 0; i < 2 * HALF_VALUES; i++)
            directed.push_back('{in_item_t'(32'h0), -1});
        // block with infinities, NaN, signed zeros and subnormals
        directed[0].pair = {16'hFF80, 16'h7F80};
        directed[1].pair = {16'h8000, 16'h7FC0};
        directed[2].pair = {16'h3F80, 16'h0000};
        directed[3].pair = {16'h0001, 16'hFFFF};
        directed[4].pair = {16'h7F7F, 16'hFF7F};
        directed[5].pair = {16'hFFC0, 16'h807F};
        directed[15].typed_expo = 254;
        // subnormal-only block: exponent clamps low
        directed[16].pair = {16'h8001, 16'h0001};
        directed[20].pair = {16'h007F, 16'h8000};
        directed[31].typed_expo = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_pair(directed[i].pair);
            if (directed[i].typed_expo >= 0 &&
                pending_bytes[$].shared_exponent != 8'(directed[i].typed_expo))
            begin
                mismatches++;
                $display("mismatch: block exponent %0d, expected %0d",
                         pending_bytes[$].shared_exponent, directed[i].typed_expo);
            end
        end

        drain_and_write(1'b1);
        send_idle_pct = 28;
        recv_idle_pct = 68;
        random_blocks(7);

        drain_and_write(1'b0);
        send_idle_pct = 68;
        recv_idle_pct = 28;
        random_blocks(7);

        drain_and_write(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = LONG_HOLD;
        random_blocks(6);

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/mxbq_pkg.sv
hdl/mxbq_front.sv
hdl/mxbq_queue.sv
hdl/mxbq_back.sv
hdl/mxfp4_block_quantizer_unit.sv
tb/testbench.sv
